[sv/psp_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the particle slot pool.
// No dependencies; psp_ctrl and particle_slot_pool_unit import this package, psp_ram does not.
package psp_pkg;

	localparam int SLOTS  = 1024;
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int LINK_W = $clog2(SLOTS + 1);
	localparam int TIME_W = 32;
	localparam int AL_W   = 2 * TIME_W;

	localparam logic [LINK_W-1:0] NONE_LINK = LINK_W'(SLOTS);

	localparam logic CMD_SPAWN = 1'b0;
	localparam logic CMD_AGE   = 1'b1;

	typedef struct packed {
		logic              cmd;
		logic [TIME_W-1:0] lifespan;
		logic [TIME_W-1:0] delta;
	} item_word_t;

	typedef struct packed {
		logic        granted;
		logic [9:0]  slot;
		logic [10:0] active_count;
	} result_word_t;

	typedef struct packed {
		logic              we;
		logic [SLOT_W-1:0] waddr;
		logic [LINK_W-1:0] wdata;
		logic              re;
		logic [SLOT_W-1:0] raddr;
	} link_req_t;

	typedef struct packed {
		logic              we;
		logic [SLOT_W-1:0] waddr;
		logic [AL_W-1:0]   wdata;
		logic              re;
		logic [SLOT_W-1:0] raddr;
	} al_req_t;

endpackage

[sv/particle_slot_pool_unit.sv]
`timescale 1ns / 1ps
// Top level of the particle slot pool: sequencer, link and age/life memories, result register.
// Depends on psp_pkg, psp_ram and psp_ctrl.
// The pool holds SLOTS slots on a free list and an active list that share one link memory;
// age and lifespan sit together in a second memory. One word is taken at a time. A spawn
// reads the free head's link at the accepting edge, writes the slot's link and age/life in
// the spawn state and then loads the result register from the emit state; a spawn on an
// exhausted pool goes straight to the emit state. An age word walks the active list through
// the link and age/life memories: each slot that expires or becomes the new head passes a
// read and an evaluate state, and each other survivor also a link state that links it behind
// the previous survivor. A result waiting in the output register does not block acceptance
// of the next word. There is no clearing pass after reset.
module particle_slot_pool_unit import psp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         item_valid,
	output logic         item_ready,
	input  item_word_t   item,
	output logic         result_valid,
	input  logic         result_ready,
	output result_word_t result
);

	link_req_t         link_req;
	al_req_t           al_req;
	logic [LINK_W-1:0] link_rdata;
	logic [AL_W-1:0]   al_rdata;
	logic              res_valid;
	result_word_t      res_word;
	logic              res_take;

	assign res_take = res_valid && (!result_valid || result_ready);

	psp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.res_valid  (res_valid),
		.res_word   (res_word),
		.res_take   (res_take),
		.link_req   (link_req),
		.link_rdata (link_rdata),
		.al_req     (al_req),
		.al_rdata   (al_rdata)
	);

	psp_ram #(
		.WIDTH (LINK_W),
		.DEPTH (SLOTS)
	) u_link_ram (
		.clk   (clk),
		.we    (link_req.we),
		.waddr (link_req.waddr),
		.wdata (link_req.wdata),
		.re    (link_req.re),
		.raddr (link_req.raddr),
		.rdata (link_rdata)
	);

	psp_ram #(
		.WIDTH (AL_W),
		.DEPTH (SLOTS)
	) u_al_ram (
		.clk   (clk),
		.we    (al_req.we),
		.waddr (al_req.waddr),
		.wdata (al_req.wdata),
		.re    (al_req.re),
		.raddr (al_req.raddr),
		.rdata (al_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (res_take) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			result <= res_word;
		end
	end

endmodule

[sv/psp_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module psp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[sv/psp_ctrl.sv]
`timescale 1ns / 1ps
// Sequencer for spawn and age words: list heads, counters and the read-modify-write
// of the link and age/life memories. Depends on psp_pkg.
module psp_ctrl import psp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  item_word_t        item,
	output logic              res_valid,
	output result_word_t      res_word,
	input  logic              res_take,
	output link_req_t         link_req,
	input  logic [LINK_W-1:0] link_rdata,
	output al_req_t           al_req,
	input  logic [AL_W-1:0]   al_rdata
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SPAWN = 3'd1;
	localparam logic [2:0] ST_RD    = 3'd2;
	localparam logic [2:0] ST_EV    = 3'd3;
	localparam logic [2:0] ST_LK    = 3'd4;
	localparam logic [2:0] ST_EMIT  = 3'd5;

	logic [2:0]        state_q;
	logic [LINK_W-1:0] free_head_q;
	logic [LINK_W-1:0] active_head_q;
	logic [LINK_W-1:0] live_count_q;
	logic [LINK_W-1:0] fresh_q;
	logic [LINK_W-1:0] cur_q;
	logic [LINK_W-1:0] nxt_q;
	logic [LINK_W-1:0] tail_q;
	logic [LINK_W-1:0] new_head_q;
	logic [LINK_W-1:0] steps_q;
	logic [TIME_W-1:0] lifespan_q;
	logic [TIME_W-1:0] delta_q;
	logic              granted_q;
	logic [SLOT_W-1:0] slot_q;

	logic [LINK_W-1:0] rd_slot;
	logic [LINK_W-1:0] link_fix;
	logic [TIME_W:0]   age_sum;
	logic [TIME_W-1:0] age_new;
	logic [TIME_W-1:0] age_old;
	logic [TIME_W-1:0] life_old;
	logic              expire;
	logic              walk_done;

	// Entries at or above the fresh mark have never been written; their link is taken
	// as the next slot instead of the memory contents.
	assign rd_slot  = (state_q == ST_SPAWN) ? free_head_q : cur_q;
	assign link_fix = (rd_slot >= fresh_q) ? rd_slot + LINK_W'(1) : link_rdata;

	assign age_old  = al_rdata[AL_W-1:TIME_W];
	assign life_old = al_rdata[TIME_W-1:0];
	assign age_sum  = {1'b0, age_old} + {1'b0, delta_q};
	assign age_new  = age_sum[TIME_W] ? {TIME_W{1'b1}} : age_sum[TIME_W-1:0];
	assign expire   = age_new > life_old;

	assign walk_done = (cur_q >= NONE_LINK) || (steps_q >= LINK_W'(SLOTS));

	assign item_ready = (state_q == ST_IDLE);
	assign res_valid  = (state_q == ST_EMIT);

	always_comb begin
		res_word.granted      = granted_q;
		res_word.slot         = 10'(slot_q);
		res_word.active_count = 11'(live_count_q);
	end

	always_comb begin
		link_req       = '0;
		al_req         = '0;
		link_req.raddr = free_head_q[SLOT_W-1:0];
		al_req.raddr   = cur_q[SLOT_W-1:0];
		unique case (state_q)
			ST_IDLE: begin
				link_req.re = 1'b1;
			end
			ST_SPAWN: begin
				link_req.we    = 1'b1;
				link_req.waddr = free_head_q[SLOT_W-1:0];
				link_req.wdata = active_head_q;
				al_req.we      = 1'b1;
				al_req.waddr   = free_head_q[SLOT_W-1:0];
				al_req.wdata   = {{TIME_W{1'b0}}, lifespan_q};
			end
			ST_RD: begin
				link_req.re    = !walk_done;
				link_req.raddr = cur_q[SLOT_W-1:0];
				al_req.re      = !walk_done;
			end
			ST_EV: begin
				link_req.we    = 1'b1;
				link_req.waddr = cur_q[SLOT_W-1:0];
				link_req.wdata = expire ? free_head_q : NONE_LINK;
				al_req.we      = 1'b1;
				al_req.waddr   = cur_q[SLOT_W-1:0];
				al_req.wdata   = {age_new, life_old};
			end
			ST_LK: begin
				link_req.we    = 1'b1;
				link_req.waddr = tail_q[SLOT_W-1:0];
				link_req.wdata = cur_q;
			end
			ST_EMIT: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			free_head_q   <= '0;
			active_head_q <= NONE_LINK;
			live_count_q  <= '0;
			fresh_q       <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						if (item.cmd == CMD_SPAWN) begin
							state_q <= (free_head_q >= NONE_LINK) ? ST_EMIT : ST_SPAWN;
						end else begin
							state_q <= ST_RD;
						end
					end
				end
				ST_SPAWN: begin
					free_head_q   <= link_fix;
					active_head_q <= free_head_q;
					live_count_q  <= live_count_q + LINK_W'(1);
					if (free_head_q == fresh_q) begin
						fresh_q <= fresh_q + LINK_W'(1);
					end
					state_q <= ST_EMIT;
				end
				ST_RD: begin
					if (walk_done) begin
						active_head_q <= new_head_q;
						state_q       <= ST_EMIT;
					end else begin
						state_q <= ST_EV;
					end
				end
				ST_EV: begin
					if (expire) begin
						free_head_q <= cur_q;
						if (live_count_q != '0) begin
							live_count_q <= live_count_q - LINK_W'(1);
						end
						state_q <= ST_RD;
					end else if (tail_q >= NONE_LINK) begin
						state_q <= ST_RD;
					end else begin
						state_q <= ST_LK;
					end
				end
				ST_LK: begin
					state_q <= ST_RD;
				end
				ST_EMIT: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				lifespan_q <= item.lifespan;
				delta_q    <= item.delta;
				cur_q      <= active_head_q;
				tail_q     <= NONE_LINK;
				new_head_q <= NONE_LINK;
				steps_q    <= '0;
				granted_q  <= 1'b0;
				slot_q     <= '0;
			end
			ST_SPAWN: begin
				granted_q <= 1'b1;
				slot_q    <= free_head_q[SLOT_W-1:0];
			end
			ST_EV: begin
				nxt_q <= link_fix;
				if (expire || tail_q >= NONE_LINK) begin
					cur_q   <= link_fix;
					steps_q <= steps_q + LINK_W'(1);
				end
				if (!expire && tail_q >= NONE_LINK) begin
					new_head_q <= cur_q;
					tail_q     <= cur_q;
				end
			end
			ST_LK: begin
				tail_q  <= cur_q;
				cur_q   <= nxt_q;
				steps_q <= steps_q + LINK_W'(1);
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTH
	a_live_bound: assert property (@(posedge clk) disable iff (!arst_n)
		live_count_q <= LINK_W'(SLOTS))
		else $error("live count exceeds the pool size");

	a_empty_active: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> ((active_head_q == NONE_LINK) == (live_count_q == '0)))
		else $error("active list head disagrees with live count");

	a_full_pool: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && free_head_q >= NONE_LINK) |-> live_count_q == LINK_W'(SLOTS))
		else $error("free list empty while slots remain unused");

	a_fresh_grows: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> fresh_q >= $past(fresh_q))
		else $error("fresh mark moved backwards");
`endif

endmodule
